// ===== hw/rtl/qoe_pkg.sv =====
// qoe_pkg: shared types, constants and helper functions of the quaternion orientation engine
// no dependencies; used by qoe_mac, qoe_rsqrt and quaternion_orientation_engine

package qoe_pkg;

  // component width and shared multiplier / accumulator widths
  localparam int QW    = 16;
  localparam int AW    = 34;
  localparam int BW    = 21;
  localparam int PW    = AW + BW;
  localparam int ACCW  = 56;
  localparam int HW    = 20;
  localparam int NW    = 39;
  localparam int RW    = 41;
  localparam int RLO_W = 33;

  localparam logic signed [ACCW-1:0] SAT_HI = ACCW'(32767);
  localparam logic signed [ACCW-1:0] SAT_LO = ACCW'(-32768);

  // component indexes, order x y z w
  localparam logic [1:0] CX = 2'd0;
  localparam logic [1:0] CY = 2'd1;
  localparam logic [1:0] CZ = 2'd2;
  localparam logic [1:0] CW = 2'd3;

  typedef enum logic [1:0] {
    MODE_COMPOSE = 2'd0,
    MODE_ROTATE  = 2'd1,
    MODE_LOAD    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  // product phases of the sequencer
  typedef enum logic [2:0] {
    PH_CP = 3'd0,  // compose hamilton product
    PH_CN = 3'd1,  // compose squared norm
    PH_CR = 3'd2,  // compose scale by rsqrt
    PH_RT = 3'd3,  // rotate t = q v
    PH_RV = 3'd4   // rotate t q*
  } phase_t;

  typedef struct packed {
    logic [1:0] a_idx;
    logic [1:0] b_idx;
    logic       neg;
  } term_t;

  typedef struct packed {
    logic                   vld;
    logic signed [AW-1:0]   a;
    logic signed [BW-1:0]   b;
    logic                   neg;
    logic                   clr;
    logic                   shl;
    logic                   last;
    logic [1:0]             dest;
  } mac_op_t;

  typedef struct packed {
    logic                   vld;
    logic [1:0]             dest;
    logic signed [ACCW-1:0] acc;
  } mac_res_t;

  typedef struct packed {
    logic signed [QW-1:0] val;
    logic                 sat;
  } rsat_t;

  // operand indexes and sign of one product term
  function automatic term_t term_sel(input phase_t ph, input logic [1:0] s,
                                     input logic [1:0] t);
    term_t r;
    r = '0;
    if (ph == PH_CP) begin
      case ({s, t})
        4'h0: r = '{CW, CX, 1'b0};
        4'h1: r = '{CX, CW, 1'b0};
        4'h2: r = '{CY, CZ, 1'b0};
        4'h3: r = '{CZ, CY, 1'b1};
        4'h4: r = '{CW, CY, 1'b0};
        4'h5: r = '{CY, CW, 1'b0};
        4'h6: r = '{CZ, CX, 1'b0};
        4'h7: r = '{CX, CZ, 1'b1};
        4'h8: r = '{CW, CZ, 1'b0};
        4'h9: r = '{CZ, CW, 1'b0};
        4'ha: r = '{CX, CY, 1'b0};
        4'hb: r = '{CY, CX, 1'b1};
        4'hc: r = '{CW, CW, 1'b0};
        4'hd: r = '{CX, CX, 1'b1};
        4'he: r = '{CY, CY, 1'b1};
        default: r = '{CZ, CZ, 1'b1};
      endcase
    end else if (ph == PH_RT) begin
      case ({s, t})
        4'h0: r = '{CW, CX, 1'b0};
        4'h1: r = '{CY, CZ, 1'b0};
        4'h2: r = '{CZ, CY, 1'b1};
        4'h4: r = '{CW, CY, 1'b0};
        4'h5: r = '{CZ, CX, 1'b0};
        4'h6: r = '{CX, CZ, 1'b1};
        4'h8: r = '{CW, CZ, 1'b0};
        4'h9: r = '{CX, CY, 1'b0};
        4'ha: r = '{CY, CX, 1'b1};
        4'hc: r = '{CX, CX, 1'b0};
        4'hd: r = '{CY, CY, 1'b0};
        4'he: r = '{CZ, CZ, 1'b0};
        default: r = '0;
      endcase
    end else if (ph == PH_RV) begin
      // a indexes t, b indexes the stored quaternion
      case ({s, t})
        4'h0: r = '{CW, CX, 1'b0};
        4'h1: r = '{CX, CW, 1'b0};
        4'h2: r = '{CZ, CY, 1'b0};
        4'h3: r = '{CY, CZ, 1'b1};
        4'h4: r = '{CW, CY, 1'b0};
        4'h5: r = '{CY, CW, 1'b0};
        4'h6: r = '{CX, CZ, 1'b0};
        4'h7: r = '{CZ, CX, 1'b1};
        4'h8: r = '{CW, CZ, 1'b0};
        4'h9: r = '{CZ, CW, 1'b0};
        4'ha: r = '{CY, CX, 1'b0};
        4'hb: r = '{CX, CY, 1'b1};
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  // round half up by 2^sh, then clamp to 16 bits
  function automatic rsat_t round_sat(input logic signed [ACCW-1:0] acc, input int sh);
    logic signed [ACCW-1:0] sum;
    logic signed [ACCW-1:0] q;
    rsat_t r;
    sum = acc + (ACCW'(1) <<< (sh - 1));
    q = sum >>> sh;
    if (q > SAT_HI) begin
      r.val = QW'(32767);
      r.sat = 1'b1;
    end else if (q < SAT_LO) begin
      r.val = QW'(-32768);
      r.sat = 1'b1;
    end else begin
      r.val = q[QW-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // round half up from 2^-28 to 2^-14 units
  function automatic logic signed [HW-1:0] round_h(input logic signed [ACCW-1:0] acc);
    logic signed [ACCW-1:0] sum;
    logic signed [ACCW-1:0] q;
    sum = acc + (ACCW'(1) <<< 13);
    q = sum >>> 14;
    return q[HW-1:0];
  endfunction

endpackage

// ===== hw/rtl/qoe_mac.sv =====
// qoe_mac: shared signed multiplier with registered product and 56-bit accumulator
// depends on qoe_pkg for the operation and result structs

module qoe_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  qoe_pkg::mac_op_t   op,
  output qoe_pkg::mac_res_t  res
);

  logic signed [qoe_pkg::PW-1:0]   prod_r;
  logic                            s1_vld_r;
  logic                            s1_neg_r;
  logic                            s1_clr_r;
  logic                            s1_shl_r;
  logic                            s1_last_r;
  logic [1:0]                      s1_dest_r;
  logic signed [qoe_pkg::ACCW-1:0] acc_r;
  logic signed [qoe_pkg::ACCW-1:0] acc_nxt;
  logic signed [qoe_pkg::ACCW-1:0] ext;
  logic signed [qoe_pkg::ACCW-1:0] term;
  logic                            res_vld_r;
  logic [1:0]                      res_dest_r;

  always_comb begin
    ext = qoe_pkg::ACCW'(prod_r);
    term = s1_shl_r ? (ext <<< qoe_pkg::RLO_W) : ext;
    acc_nxt = (s1_clr_r ? '0 : acc_r) + (s1_neg_r ? -term : term);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= op.vld;
      res_vld_r <= s1_vld_r & s1_last_r;
    end
    prod_r    <= qoe_pkg::PW'(op.a) * qoe_pkg::PW'(op.b);
    s1_neg_r  <= op.neg;
    s1_clr_r  <= op.clr;
    s1_shl_r  <= op.shl;
    s1_last_r <= op.last;
    s1_dest_r <= op.dest;
    res_dest_r <= s1_dest_r;
    if (s1_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign res.vld  = res_vld_r;
  assign res.dest = res_dest_r;
  assign res.acc  = acc_r;

endmodule

// ===== hw/rtl/qoe_rsqrt.sv =====
// qoe_rsqrt: exactly rounded 2^40 / sqrt(n), as floor((isqrt(floor(2^82 / n)) + 1) / 2)
// bit-serial restoring divide then digit-by-digit square root; depends on qoe_pkg widths

module qoe_rsqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [qoe_pkg::NW-1:0]   n,
  output logic                     done,
  output logic [qoe_pkg::RW-1:0]   r
);

  localparam int QB   = 2 * qoe_pkg::RW + 2;  // padded quotient, even bit count
  localparam int RB   = qoe_pkg::RW + 5;      // root remainder
  localparam int ROOTW = qoe_pkg::RW + 1;
  localparam logic [6:0] DIV_TOP = 7'(QB - 2);
  localparam logic [6:0] SQ_TOP  = 7'(QB / 2 - 1);

  typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} rst_t;

  rst_t                    st_r;
  logic [6:0]              cnt_r;
  logic [RB-1:0]           rem_r;
  logic [QB-1:0]           quo_r;
  logic [ROOTW-1:0]        root_r;
  logic                    done_r;
  logic [qoe_pkg::NW:0]    div_sh;
  logic                    div_ge;
  logic [RB-1:0]           sq_sh;
  logic [RB-1:0]           sq_trial;
  logic                    sq_ge;
  logic [ROOTW:0]          root_inc;

  always_comb begin
    div_sh   = {rem_r[qoe_pkg::NW-1:0], cnt_r == DIV_TOP};
    div_ge   = div_sh >= {1'b0, n};
    sq_sh    = {rem_r[RB-3:0], quo_r[QB-1:QB-2]};
    sq_trial = {2'b00, root_r, 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    root_inc = {1'b0, root_r} + (ROOTW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= R_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= (st_r == R_SQRT) && (cnt_r == '0);
      unique case (st_r)
        R_IDLE: begin
          if (start) begin
            st_r   <= R_DIV;
            cnt_r  <= DIV_TOP;
            rem_r  <= '0;
            quo_r  <= '0;
            root_r <= '0;
          end
        end
        R_DIV: begin
          // remainder restarts at zero for the root steps
          rem_r <= (cnt_r == '0) ? '0
                 : (div_ge ? RB'(div_sh - {1'b0, n}) : RB'(div_sh));
          quo_r <= {quo_r[QB-2:0], div_ge};
          if (cnt_r == '0) begin
            st_r  <= R_SQRT;
            cnt_r <= SQ_TOP;
          end else begin
            cnt_r <= cnt_r - 7'd1;
          end
        end
        R_SQRT: begin
          rem_r  <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
          root_r <= {root_r[ROOTW-2:0], sq_ge};
          quo_r  <= {quo_r[QB-3:0], 2'b00};
          if (cnt_r == '0) begin
            st_r <= R_IDLE;
          end else begin
            cnt_r <= cnt_r - 7'd1;
          end
        end
        default: st_r <= R_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign r    = root_inc[qoe_pkg::RW:1];

endmodule

// ===== hw/rtl/quaternion_orientation_engine.sv =====
// quaternion_orientation_engine: top level, sequencer and state around one shared multiplier
// depends on qoe_pkg, qoe_mac and qoe_rsqrt
//
// channel  direction  handshake            payload
// in       input      in_valid / in_ready  in_mode, in_x, in_y, in_z, in_w
// out      output     out_valid/out_ready  out_x, out_y, out_z, out_w, out_saturated
//
// one item at a time: in_ready is high only when no item is in work or waiting
// compose: 16 + 4 products on the shared multiplier, the rsqrt unit (restoring divide
// steps, then square-root steps, one bit each), then 8 scaling products
// rotate: 24 products; load and the unused mode skip the multiplier
// synchronous active-low reset puts the orientation at identity (w = 16384)
// a result holds on the out ports until its transfer; the next input waits for it

module quaternion_orientation_engine (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_mode,
  input  logic signed [15:0]       in_x,
  input  logic signed [15:0]       in_y,
  input  logic signed [15:0]       in_z,
  input  logic signed [15:0]       in_w,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [15:0]       out_x,
  output logic signed [15:0]       out_y,
  output logic signed [15:0]       out_z,
  output logic signed [15:0]       out_w,
  output logic                     out_saturated
);

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_WAIT, S_RSQ_GO, S_RSQ_WAIT, S_DONE
  } state_t;

  localparam logic signed [qoe_pkg::QW-1:0] Q_ONE = qoe_pkg::QW'(16384);

  state_t                          state_r;
  qoe_pkg::phase_t                 phase_r;
  qoe_pkg::mode_t                  mode_r;
  logic [1:0]                      sum_r;
  logic [1:0]                      term_r;
  logic                            wait_r;
  logic signed [qoe_pkg::QW-1:0]   q_r   [4];
  logic signed [qoe_pkg::QW-1:0]   in_r  [4];
  logic signed [qoe_pkg::HW-1:0]   h_r   [4];
  logic signed [qoe_pkg::AW-1:0]   t_r   [4];
  logic signed [qoe_pkg::QW-1:0]   res_r [4];
  logic                            sat_r;
  logic [qoe_pkg::NW-1:0]          n_r;

  // sequencer side
  qoe_pkg::term_t                  tsel;
  logic [1:0]                      q_idx;
  logic [1:0]                      h_idx;
  logic signed [qoe_pkg::QW-1:0]   q_rd;
  logic signed [qoe_pkg::QW-1:0]   in_rd;
  logic signed [qoe_pkg::AW-1:0]   t_rd;
  logic signed [qoe_pkg::HW-1:0]   h_rd;
  logic [1:0]                      last_sum;
  logic [1:0]                      last_term;
  qoe_pkg::mac_op_t                mac_op;
  qoe_pkg::mac_res_t               mac_res;
  qoe_pkg::rsat_t                  cr_rs;
  qoe_pkg::rsat_t                  rv_rs;
  logic                            rsq_start;
  logic                            rsq_done;
  logic [qoe_pkg::RW-1:0]          rsq_r;
  logic                            in_is_load;

  // sums and terms per phase
  always_comb begin
    unique case (phase_r)
      qoe_pkg::PH_CP: begin last_sum = 2'd3; last_term = 2'd3; end
      qoe_pkg::PH_CN: begin last_sum = 2'd0; last_term = 2'd3; end
      qoe_pkg::PH_CR: begin last_sum = 2'd3; last_term = 2'd1; end
      qoe_pkg::PH_RT: begin last_sum = 2'd3; last_term = 2'd2; end
      qoe_pkg::PH_RV: begin last_sum = 2'd2; last_term = 2'd3; end
      default:        begin last_sum = 2'd0; last_term = 2'd0; end
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    tsel  = qoe_pkg::term_sel(phase_r, sum_r, term_r);
    q_idx = (phase_r == qoe_pkg::PH_RV) ? tsel.b_idx : tsel.a_idx;
    h_idx = (phase_r == qoe_pkg::PH_CN) ? term_r : sum_r;
    q_rd  = q_r[q_idx];
    in_rd = in_r[tsel.b_idx];
    t_rd  = t_r[tsel.a_idx];
    h_rd  = h_r[h_idx];

    mac_op.vld  = (state_r == S_ISSUE);
    mac_op.neg  = tsel.neg;
    mac_op.clr  = (term_r == 2'd0);
    mac_op.shl  = (phase_r == qoe_pkg::PH_CR) && (term_r == 2'd1);
    mac_op.last = (term_r == last_term);
    mac_op.dest = sum_r;
    unique case (phase_r)
      qoe_pkg::PH_CP, qoe_pkg::PH_RT: begin
        mac_op.a = qoe_pkg::AW'(q_rd);
        mac_op.b = qoe_pkg::BW'(in_rd);
      end
      qoe_pkg::PH_RV: begin
        mac_op.a = t_rd;
        mac_op.b = qoe_pkg::BW'(q_rd);
      end
      qoe_pkg::PH_CN: begin
        mac_op.a = qoe_pkg::AW'(h_rd);
        mac_op.b = qoe_pkg::BW'(h_rd);
      end
      qoe_pkg::PH_CR: begin
        // r split into low 33 bits and high part shifted back in the accumulator
        mac_op.a = (term_r == 2'd0) ? qoe_pkg::AW'(rsq_r[qoe_pkg::RLO_W-1:0])
                                    : qoe_pkg::AW'(rsq_r[qoe_pkg::RW-1:qoe_pkg::RLO_W]);
        mac_op.b = qoe_pkg::BW'(h_rd);
      end
      default: begin
        mac_op.a = '0;
        mac_op.b = '0;
      end
    endcase
  end

  always_comb begin
    cr_rs      = qoe_pkg::round_sat(mac_res.acc, 26);
    rv_rs      = qoe_pkg::round_sat(mac_res.acc, 28);
    rsq_start  = (state_r == S_RSQ_GO) && (n_r != '0);
    in_is_load = (qoe_pkg::mode_t'(in_mode) == qoe_pkg::MODE_LOAD);
  end

  qoe_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (mac_op),
    .res   (mac_res)
  );

  qoe_rsqrt u_rsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rsq_start),
    .n     (n_r),
    .done  (rsq_done),
    .r     (rsq_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= qoe_pkg::PH_CP;
      mode_r  <= qoe_pkg::MODE_NONE;
      sum_r   <= '0;
      term_r  <= '0;
      wait_r  <= 1'b0;
      q_r[0]  <= '0;
      q_r[1]  <= '0;
      q_r[2]  <= '0;
      q_r[3]  <= Q_ONE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r  <= qoe_pkg::mode_t'(in_mode);
            in_r[0] <= in_x;
            in_r[1] <= in_y;
            in_r[2] <= in_z;
            in_r[3] <= in_w;
            sat_r   <= 1'b0;
            sum_r   <= '0;
            term_r  <= '0;
            // load returns its input, every other mode starts from zeros
            res_r[0] <= in_is_load ? in_x : '0;
            res_r[1] <= in_is_load ? in_y : '0;
            res_r[2] <= in_is_load ? in_z : '0;
            res_r[3] <= in_is_load ? in_w : '0;
            unique case (qoe_pkg::mode_t'(in_mode))
              qoe_pkg::MODE_COMPOSE: begin
                phase_r <= qoe_pkg::PH_CP;
                state_r <= S_ISSUE;
              end
              qoe_pkg::MODE_ROTATE: begin
                phase_r <= qoe_pkg::PH_RT;
                state_r <= S_ISSUE;
              end
              qoe_pkg::MODE_LOAD: begin
                state_r  <= S_DONE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_ISSUE: begin
          if (term_r == last_term) begin
            term_r <= '0;
            if (sum_r == last_sum) begin
              state_r <= S_WAIT;
              wait_r  <= 1'b1;
            end else begin
              sum_r <= sum_r + 2'd1;
            end
          end else begin
            term_r <= term_r + 2'd1;
          end
        end
        S_WAIT: begin
          // wait out the product and accumulator registers of the multiplier before the last sum lands
          if (wait_r) begin
            wait_r <= 1'b0;
          end else begin
            sum_r  <= '0;
            term_r <= '0;
            unique case (phase_r)
              qoe_pkg::PH_CP: begin
                phase_r <= qoe_pkg::PH_CN;
                state_r <= S_ISSUE;
              end
              qoe_pkg::PH_CN: state_r <= S_RSQ_GO;
              qoe_pkg::PH_RT: begin
                phase_r <= qoe_pkg::PH_RV;
                state_r <= S_ISSUE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_RSQ_GO: begin
          // zero norm leaves the all-zero result in place
          state_r <= (n_r == '0) ? S_DONE : S_RSQ_WAIT;
        end
        S_RSQ_WAIT: begin
          if (rsq_done) begin
            phase_r <= qoe_pkg::PH_CR;
            state_r <= S_ISSUE;
          end
        end
        S_DONE: begin
          if (out_ready) begin
            state_r <= S_IDLE;
            if (mode_r == qoe_pkg::MODE_COMPOSE || mode_r == qoe_pkg::MODE_LOAD) begin
              for (int i = 0; i < 4; i++) begin
                q_r[i] <= res_r[i];
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // finished sums from the multiplier
      if (mac_res.vld) begin
        unique case (phase_r)
          qoe_pkg::PH_CP: h_r[mac_res.dest] <= qoe_pkg::round_h(mac_res.acc);
          qoe_pkg::PH_CN: n_r <= mac_res.acc[qoe_pkg::NW-1:0];
          qoe_pkg::PH_RT: t_r[mac_res.dest] <= mac_res.acc[qoe_pkg::AW-1:0];
          qoe_pkg::PH_CR: begin
            res_r[mac_res.dest] <= cr_rs.val;
            sat_r <= sat_r | cr_rs.sat;
          end
          qoe_pkg::PH_RV: begin
            res_r[mac_res.dest] <= rv_rs.val;
            sat_r <= sat_r | rv_rs.sat;
          end
          default: ;
        endcase
      end
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = (state_r == S_DONE);
  assign out_x         = res_r[0];
  assign out_y         = res_r[1];
  assign out_z         = res_r[2];
  assign out_w         = res_r[3];
  assign out_saturated = sat_r;

`ifndef ASSERT_OFF
  a_mac_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    mac_res.vld |-> (state_r == S_ISSUE || state_r == S_WAIT))
    else $error("multiplier sum finished outside a product phase");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again while an item is in work");

  a_rsq_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rsq_done |-> (state_r == S_RSQ_WAIT))
    else $error("rsqrt finished while not awaited");

  a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RSQ_GO && n_r == '0) |=> (state_r == S_DONE && !out_saturated))
    else $error("zero norm did not finish with a clean zero result");
`endif

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for quaternion_orientation_engine
// depends on qoe_pkg (mode codes) and the engine rtl; own predictor of the orientation math
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    qoe_pkg::mode_t       mode;
    logic signed [15:0]   x, y, z, w;
  } quat_item_t;

  typedef struct {
    logic signed [15:0]   x, y, z, w;
    logic                 sat;
  } quat_res_t;

  localparam int LIMIT_CYCLES = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = qoe_pkg::MODE_LOAD;
  logic signed [15:0] in_x = '0, in_y = '0, in_z = '0, in_w = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_x, out_y, out_z, out_w;
  logic out_saturated;

  quaternion_orientation_engine uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_w(in_w),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w),
    .out_saturated(out_saturated)
  );

  always #2 clk = ~clk;

  // pending input items, expected results, bookkeeping
  quat_item_t pend_items[$];
  quat_res_t  want_res[$];
  longint     orient[4];          // predicted stored quaternion, order x y z w
  int         n_total;
  int         n_issued = 0;
  int         n_accepted = 0;
  int         n_results = 0;
  int         n_errors = 0;
  int         n_sat = 0;
  int         mode_cnt[4] = '{0, 0, 0, 0};
  int         cycle = 0;

  // ---------------- predictor ----------------

  function automatic longint rnd_shift(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;   // arithmetic shift floors
  endfunction

  function automatic longint clamp16(longint v, ref logic flag);
    if (v > 32767) begin
      flag = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      flag = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  // largest r with (2r-1)^2 * n <= 2^82, i.e. 2^40/sqrt(n) rounded half up
  function automatic longint inv_sqrt40(longint n);
    logic [127:0] lo, hi, mid, a;
    lo = 128'd1;
    hi = 128'd1 << 40;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      a = 2 * mid - 1;
      if (a * a * 128'(n) <= (128'd1 << 82)) lo = mid;
      else hi = mid - 1;
    end
    return longint'(lo);
  endfunction

  function automatic quat_res_t orient_step(quat_item_t it);
    quat_res_t r;
    longint ix, iy, iz, iw, x, y, z, w, n, rs;
    longint p[4], h[4], res[4], t0, t1, t2, t3;
    logic flag;
    ix = longint'(it.x); iy = longint'(it.y); iz = longint'(it.z); iw = longint'(it.w);
    x = orient[0]; y = orient[1]; z = orient[2]; w = orient[3];
    res = '{0, 0, 0, 0};
    flag = 1'b0;
    case (it.mode)
      qoe_pkg::MODE_COMPOSE: begin
        p[0] = w * ix + x * iw + y * iz - z * iy;
        p[1] = w * iy + y * iw + z * ix - x * iz;
        p[2] = w * iz + z * iw + x * iy - y * ix;
        p[3] = w * iw - x * ix - y * iy - z * iz;
        n = 0;
        for (int i = 0; i < 4; i++) begin
          h[i] = rnd_shift(p[i], 14);
          n += h[i] * h[i];
        end
        // zero norm collapses the orientation to all zeros
        if (n != 0) begin
          rs = inv_sqrt40(n);
          for (int i = 0; i < 4; i++) res[i] = clamp16(rnd_shift(h[i] * rs, 26), flag);
        end
        for (int i = 0; i < 4; i++) orient[i] = res[i];
      end
      qoe_pkg::MODE_ROTATE: begin
        t0 = w * ix + y * iz - z * iy;
        t1 = w * iy + z * ix - x * iz;
        t2 = w * iz + x * iy - y * ix;
        t3 = x * ix + y * iy + z * iz;
        res[0] = clamp16(rnd_shift(t3 * x + t0 * w + t2 * y - t1 * z, 28), flag);
        res[1] = clamp16(rnd_shift(t3 * y + t1 * w + t0 * z - t2 * x, 28), flag);
        res[2] = clamp16(rnd_shift(t3 * z + t2 * w + t1 * x - t0 * y, 28), flag);
      end
      qoe_pkg::MODE_LOAD: begin
        res = '{ix, iy, iz, iw};
        for (int i = 0; i < 4; i++) orient[i] = res[i];
      end
      default: ;  // unused mode: zeros, state kept
    endcase
    r.x = res[0][15:0]; r.y = res[1][15:0]; r.z = res[2][15:0]; r.w = res[3][15:0];
    r.sat = flag;
    return r;
  endfunction

  // ---------------- stimulus ----------------

  function automatic logic signed [15:0] any16();
    case ($urandom_range(0, 11))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] near(int c, int span);
    return 16'(c + $urandom_range(0, 2 * span) - span);
  endfunction

  task automatic add_item(qoe_pkg::mode_t m, int x, int y, int z, int w);
    quat_item_t it;
    it.mode = m;
    it.x = 16'(x); it.y = 16'(y); it.z = 16'(z); it.w = 16'(w);
    pend_items.push_back(it);
  endtask

  task automatic fill_items();
    quat_item_t it;
    int sel;
    // directed: identity use, extremes, zero norm, unused mode, saturating rotation
    add_item(qoe_pkg::MODE_ROTATE, 1000, -2000, 3000, 0);
    add_item(qoe_pkg::MODE_COMPOSE, 0, 0, 0, 16384);
    add_item(qoe_pkg::MODE_COMPOSE, 11585, 0, 0, 11585);
    add_item(qoe_pkg::MODE_ROTATE, 0, 32767, -32768, 5);
    add_item(qoe_pkg::MODE_NONE, 1, 2, 3, 4);
    add_item(qoe_pkg::MODE_LOAD, -32768, -32768, -32768, -32768);
    add_item(qoe_pkg::MODE_ROTATE, 32767, -32768, 32767, 0);
    add_item(qoe_pkg::MODE_COMPOSE, 32767, 32767, 32767, 32767);
    add_item(qoe_pkg::MODE_LOAD, 32767, 32767, 32767, 32767);
    add_item(qoe_pkg::MODE_ROTATE, -32768, -32768, -32768, -1);
    add_item(qoe_pkg::MODE_COMPOSE, -32768, 32767, 0, -1);
    add_item(qoe_pkg::MODE_LOAD, 0, 0, 0, 0);
    add_item(qoe_pkg::MODE_ROTATE, 100, 200, 300, 0);
    add_item(qoe_pkg::MODE_COMPOSE, 0, 0, 0, 16384);       // zero norm from zero state
    add_item(qoe_pkg::MODE_LOAD, 0, 0, 0, 16384);
    add_item(qoe_pkg::MODE_COMPOSE, 0, 0, 0, 0);           // zero norm from zero input
    add_item(qoe_pkg::MODE_LOAD, 1, -1, 1, -1);
    add_item(qoe_pkg::MODE_COMPOSE, 1, 1, -1, 1);          // tiny operands round to a zero norm
    add_item(qoe_pkg::MODE_ROTATE, 32767, 32767, 32767, 0);
    add_item(qoe_pkg::MODE_LOAD, 0, 0, 0, -32768);
    add_item(qoe_pkg::MODE_ROTATE, -32768, 32767, -32768, 0);
    add_item(qoe_pkg::MODE_NONE, -32768, 32767, -1, 0);
    add_item(qoe_pkg::MODE_LOAD, 0, 11585, 0, 11585);
    add_item(qoe_pkg::MODE_ROTATE, 32767, 0, -32768, 0);
    // random: small-angle and arbitrary composes, arbitrary rotations, loads and some unused modes
    for (int k = 0; k < 1380; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        it.mode = qoe_pkg::MODE_COMPOSE;
        it.x = near(0, 800); it.y = near(0, 800); it.z = near(0, 800);
        it.w = near(16384, 200);
      end else if (sel < 45) begin
        it.mode = qoe_pkg::MODE_COMPOSE;
        it.x = any16(); it.y = any16(); it.z = any16(); it.w = any16();
      end else if (sel < 75) begin
        it.mode = qoe_pkg::MODE_ROTATE;
        it.x = any16(); it.y = any16(); it.z = any16(); it.w = 16'($urandom);
      end else if (sel < 88) begin
        it.mode = qoe_pkg::MODE_LOAD;
        it.x = near(0, 9000); it.y = near(0, 9000); it.z = near(0, 9000);
        it.w = near(0, 16000);
      end else if (sel < 95) begin
        it.mode = qoe_pkg::MODE_LOAD;
        it.x = any16(); it.y = any16(); it.z = any16(); it.w = any16();
      end else begin
        it.mode = qoe_pkg::MODE_NONE;
        it.x = any16(); it.y = any16(); it.z = any16(); it.w = any16();
      end
      pend_items.push_back(it);
    end
  endtask

  // ---------------- driver: changes at falling edge ----------------

  // quiet window with no idling on either side
  function automatic logic quiet();
    return (n_accepted >= 500 && n_accepted < 700);
  endfunction

  always @(negedge clk) begin
    quat_item_t it;
    if (rst_n && !(in_valid && n_accepted != n_issued)) begin
      // previous transfer done or nothing offered: maybe offer the next item
      if (pend_items.size() != 0 && (quiet() || $urandom_range(0, 99) >= 30)) begin
        it = pend_items.pop_front();
        in_valid <= 1'b1;
        in_mode  <= it.mode;
        in_x <= it.x; in_y <= it.y; in_z <= it.z; in_w <= it.w;
        n_issued <= n_issued + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off counted here
  int hold_left = 0;
  logic hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted == 300) begin
      // sender keeps offering while the result sits unread
      out_ready <= 1'b0;
      hold_left <= 600;
      hold_done <= 1'b1;
    end else begin
      out_ready <= quiet() || ($urandom_range(0, 99) >= 30);
    end
  end

  // ---------------- monitor: sampled at rising edge ----------------

  always @(posedge clk) begin
    quat_item_t it;
    quat_res_t  e;
    if (rst_n && in_valid && in_ready) begin
      it.mode = qoe_pkg::mode_t'(in_mode);
      it.x = in_x; it.y = in_y; it.z = in_z; it.w = in_w;
      want_res.push_back(orient_step(it));
      mode_cnt[in_mode]++;
      n_accepted <= n_accepted + 1;
    end
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (out_saturated) n_sat++;
      if (want_res.size() == 0) begin
        $display("%0t: result transfer with nothing expected: x=%0d y=%0d z=%0d w=%0d sat=%0b",
                 $time, out_x, out_y, out_z, out_w, out_saturated);
        n_errors++;
      end else begin
        e = want_res.pop_front();
        if (out_x !== e.x) begin
          $display("%0t: out_x expected %0d actual %0d", $time, e.x, out_x);
          n_errors++;
        end
        if (out_y !== e.y) begin
          $display("%0t: out_y expected %0d actual %0d", $time, e.y, out_y);
          n_errors++;
        end
        if (out_z !== e.z) begin
          $display("%0t: out_z expected %0d actual %0d", $time, e.z, out_z);
          n_errors++;
        end
        if (out_w !== e.w) begin
          $display("%0t: out_w expected %0d actual %0d", $time, e.w, out_w);
          n_errors++;
        end
        if (out_saturated !== e.sat) begin
          $display("%0t: out_saturated expected %0b actual %0b", $time, e.sat, out_saturated);
          n_errors++;
        end
      end
    end
  end

  // timeout guard
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle, want_res.size());
      $display("[quaternion_orientation_engine] ERROR");
      $finish;
    end
  end

  // ---------------- sequence ----------------

  initial begin
    orient = '{0, 0, 0, 16384};
    fill_items();
    n_total = pend_items.size();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // all items handed over and every result back
    wait (n_accepted == n_total && want_res.size() == 0);
    repeat (300) @(posedge clk);
    if (want_res.size() != 0) begin
      $display("%0d expected results never arrived", want_res.size());
      n_errors++;
    end
    $display("covered %0d transfers: %0d compose, %0d rotate, %0d load, %0d unused mode",
             n_total, mode_cnt[qoe_pkg::MODE_COMPOSE], mode_cnt[qoe_pkg::MODE_ROTATE],
             mode_cnt[qoe_pkg::MODE_LOAD], mode_cnt[qoe_pkg::MODE_NONE]);
    $display("%0d results checked, %0d saturated, %0d mismatches", n_results, n_sat, n_errors);
    if (n_errors == 0) begin
      $display("[quaternion_orientation_engine] OK");
    end else begin
      $display("[quaternion_orientation_engine] ERROR");
    end
    $finish;
  end

endmodule
